// File: rtl/evm_pkg.sv
// Shared types, widths and codes for the encoder velocity moving-average block.
package evm_pkg;

  // Window length of the moving average.
  localparam int WINDOW = 10;

  // Field widths.
  localparam int COUNT_W = 15;
  localparam int DELTA_W = COUNT_W + 1;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 32;

  // Running sum holds WINDOW deltas of any value.
  localparam int SUM_W  = DELTA_W + $clog2(WINDOW);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int HELD_W = $clog2(WINDOW + 1);

  // Multiplier results: signed operand times zero-extended gain.
  localparam int RAW_W  = DELTA_W + GAIN_W + 1;
  localparam int PROD_W = SUM_W + GAIN_W + 1;

  // Divider: DIV_BITS quotient bits per cycle.
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = (PROD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int QUO_W     = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Stream packing.
  localparam int IN_TDATA_W  = ((COUNT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * SPEED_W + 7) / 8) * 8;

  // Queue between front and back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register reset value: 2*pi/(1000*0.01) in Q0.16.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd41177;

  // One classified sample handed from the front end to the back end.
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic [HELD_W-1:0]         held;
  } evm_item_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ABS,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

// File: rtl/evm_front.sv
// Front end: takes counter samples, forms deltas and keeps the window ring and running sum.
module evm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [evm_pkg::COUNT_W-1:0]  encoder_count,
  input  logic                                q_full,
  output logic                                q_push,
  output evm_pkg::evm_item_t                  q_item
);
  import evm_pkg::*;

  logic signed [COUNT_W-1:0] prev_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [SLOT_W-1:0]         slot_nxt;
  logic                      full_r;
  logic                      full_nxt;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [DELTA_W-1:0] ring_r [WINDOW];
  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W-1:0] oldest;
  logic                      last_slot;
  logic [HELD_W-1:0]         held;

  // Accept whenever the queue has room.
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Delta, updated running sum and slot bookkeeping.
  always_comb begin
    delta     = DELTA_W'(encoder_count) - DELTA_W'(prev_r);
    oldest    = ring_r[slot_r];
    last_slot = (slot_r == SLOT_W'(WINDOW - 1));
    sum_nxt   = sum_r + SUM_W'(delta) - (full_r ? SUM_W'(oldest) : SUM_W'(0));
    slot_nxt  = last_slot ? '0 : slot_r + SLOT_W'(1);
    full_nxt  = full_r || last_slot;
    held      = full_nxt ? HELD_W'(WINDOW) : HELD_W'(slot_r) + HELD_W'(1);
  end

  assign q_item = '{delta: delta, sum: sum_nxt, held: held};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      slot_r <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
    end else if (q_push) begin
      prev_r <= encoder_count;
      slot_r <= slot_nxt;
      full_r <= full_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Window ring: an entry is only read back once it has been written.
  always_ff @(posedge clk) begin
    if (q_push) begin
      ring_r[slot_r] <= delta;
    end
  end

endmodule

// File: rtl/evm_queue.sv
// Short FIFO that decouples the front end from the back end.
module evm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  evm_pkg::evm_item_t push_item,
  output logic               full,
  input  logic               pop,
  output evm_pkg::evm_item_t pop_item,
  output logic               empty
);
  import evm_pkg::*;

  evm_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // The fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count above depth");

  // Neighbors never push into a full queue or pop an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");

endmodule

// File: rtl/evm_back.sv
// Back end: gain multiply, iterative divide by the held count, and the result register.
module evm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [evm_pkg::GAIN_W-1:0]         speed_gain,
  input  logic                               q_empty,
  input  evm_pkg::evm_item_t                 q_item,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic signed [evm_pkg::SPEED_W-1:0] inst_rate,
  output logic signed [evm_pkg::SPEED_W-1:0] avg_rate
);
  import evm_pkg::*;

  bk_state_t                 state_r;
  bk_state_t                 state_nxt;
  logic [STEP_W-1:0]         step_r;
  logic                      out_load;
  logic                      out_tvalid_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [HELD_W-1:0]         held_r;
  logic signed [RAW_W-1:0]   raw_full;
  logic signed [PROD_W-1:0]  prod_full;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SPEED_W-1:0] raw_r;
  logic [PROD_W-1:0]         mag;
  logic                      neg_r;
  logic [QUO_W-1:0]          quo_r;
  logic [QUO_W-1:0]          quo_nxt;
  logic [HELD_W-1:0]         rem_r;
  logic [HELD_W-1:0]         rem_nxt;
  logic [HELD_W:0]           trial;
  logic [SPEED_W-1:0]        quo_low;
  logic signed [SPEED_W-1:0] raw_out_r;
  logic signed [SPEED_W-1:0] filt_out_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_ABS;
      BK_ABS:  state_nxt = BK_DIV;
      BK_DIV:  if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = BK_DONE;
      BK_DONE: if (!out_tvalid_r || out_tready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE: q_pop    = !q_empty;
      BK_DONE: out_load = !out_tvalid_r || out_tready;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Multipliers: signed operand times the zero-extended unsigned gain.
  assign raw_full  = RAW_W'(delta_r) * RAW_W'($signed({1'b0, speed_gain}));
  assign prod_full = PROD_W'(sum_r) * PROD_W'($signed({1'b0, speed_gain}));
  assign mag       = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  // Restoring division, DIV_BITS quotient bits per cycle; the dividend shifts
  // out of the top of quo_r while quotient bits enter at the bottom.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial   = {rem_nxt, quo_nxt[QUO_W-1]};
      quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, held_r}) begin
        trial      = trial - {1'b0, held_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[HELD_W-1:0];
    end
  end

  assign quo_low = quo_r[SPEED_W-1:0];

  // Sequencer state and step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_DIV) begin
        step_r <= step_r + STEP_W'(1);
      end else begin
        step_r <= '0;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      delta_r <= q_item.delta;
      sum_r   <= q_item.sum;
      held_r  <= q_item.held;
    end
    case (state_r)
      BK_MUL: begin
        raw_r  <= raw_full[SPEED_W-1:0];
        prod_r <= prod_full;
      end
      BK_ABS: begin
        neg_r <= prod_r[PROD_W-1];
        quo_r <= QUO_W'(mag);
        rem_r <= '0;
      end
      BK_DIV: begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      raw_out_r  <= raw_r;
      filt_out_r <= neg_r ? $signed(-quo_low) : $signed(quo_low);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign inst_rate  = raw_out_r;
  assign avg_rate   = filt_out_r;

  // The step counter stays inside the divide sequence.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (step_r < STEP_W'(DIV_STEPS)))
    else $error("divider step counter out of range");

  // A request leaves the queue only when the sequencer is idle, and then it multiplies next.
  a_pop_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == BK_MUL))
    else $error("popped request not followed by multiply");

endmodule

// File: rtl/encoder_velocity_moving_average.sv
// Top level of the encoder speed estimator with moving-average filter.
//
//  Channel  Direction  Handshake                Payload
//  in_      input      in_tvalid / in_tready    in_tdata[14:0] encoder_count
//  out_     output     out_tvalid / out_tready  out_tdata[31:0] instantaneous speed,
//                                               out_tdata[63:32] averaged speed
//  cfg_     input      cfg_valid / cfg_ready    cfg_data[15:0] speed_gain
//
// Each request holds the back end while it is popped from the queue, multiplied,
// turned into a magnitude, divided at three quotient bits per cycle, and handed
// to the result register; the hand-off waits while a stalled result is held.
// The front end accepts a request whenever the two-entry queue has room.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds its result while the back end may start the next request.
module encoder_velocity_moving_average (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [evm_pkg::IN_TDATA_W-1:0]      in_tdata,   // [14:0] encoder_count
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [evm_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] inst, [63:32] average
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [evm_pkg::GAIN_W-1:0]          cfg_data
);
  import evm_pkg::*;

  logic [GAIN_W-1:0]         gain_r;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_empty;
  evm_item_t                 push_item;
  evm_item_t                 pop_item;
  logic signed [SPEED_W-1:0] inst_rate;
  logic signed [SPEED_W-1:0] avg_rate;

  // Gain register, always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain_r <= cfg_data;
    end
  end

  evm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .encoder_count ($signed(in_tdata[COUNT_W-1:0])),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  evm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  evm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .speed_gain (gain_r),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .inst_rate  (inst_rate),
    .avg_rate   (avg_rate)
  );

  // Pack the result, first field lowest.
  assign out_tdata = OUT_TDATA_W'({avg_rate, inst_rate});

endmodule

// File: tb/tb.sv
// Self-checking testbench for the encoder speed estimator with moving-average filter.
`timescale 1ns / 1ps

module tb;
  import evm_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_SEGMENTS = 6;
  localparam int SEGMENT_ITEMS   = 325;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_LIMIT    = 10;
  localparam int GAIN_KEEP       = -1;
  localparam int COUNT_MAX       = 2 ** (COUNT_W - 1) - 1;
  localparam int COUNT_MIN       = -(2 ** (COUNT_W - 1));
  localparam int DIRECTED_ROWS   = 22;

  // One result: both speeds in signed Q16.16.
  typedef struct packed {
    logic signed [SPEED_W-1:0] filt;
    logic signed [SPEED_W-1:0] raw;
  } speed_t;

  // One directed row: optional gain change, counter value, optional fixed result.
  typedef struct packed {
    int gain;
    int count;
    bit typed;
    int raw;
    int filt;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [GAIN_W-1:0]      cfg_data   = '0;

  // Speed estimator state kept alongside the block.
  logic signed [COUNT_W-1:0] est_prev = '0;
  longint                    est_ring[WINDOW];
  int                        est_slot = 0;
  bit                        est_full = 1'b0;
  longint                    est_sum  = 0;
  logic [GAIN_W-1:0]         est_gain = GAIN_RESET;

  speed_t   pending_speeds[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       rx_hold = 1'b0;
  bit       pressure_go = 1'b0;
  bit       row_typed = 1'b0;
  speed_t   row_speed;
  dir_row_t dir_rows[DIRECTED_ROWS];

  encoder_velocity_moving_average u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [14:0] encoder_count
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [31:0] instantaneous speed, [63:32] averaged speed
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Advance the speed estimate by one counter sample and return both speeds.
  function automatic void estimate_speed(input logic signed [COUNT_W-1:0] cnt,
                                         output speed_t res);
    longint delta;
    longint held;
    longint raw_full;
    longint filt_full;
    delta = longint'(cnt) - longint'(est_prev);
    if (est_full) begin
      est_sum -= est_ring[est_slot];
    end
    est_sum += delta;
    est_ring[est_slot] = delta;
    est_slot++;
    if (est_slot >= WINDOW) begin
      est_slot = 0;
      est_full = 1'b1;
    end
    held = est_full ? WINDOW : est_slot;
    raw_full = delta * longint'(est_gain);
    filt_full = (est_sum * longint'(est_gain)) / held;
    res.raw = raw_full[SPEED_W-1:0];
    res.filt = filt_full[SPEED_W-1:0];
    est_prev = cnt;
  endfunction

  // Mostly a plausible encoder walk, with jumps, full-range values and extremes.
  function automatic int next_encoder_count(input int last);
    int pick;
    int c;
    pick = $urandom_range(99);
    if (pick < 65) begin
      c = last + int'($urandom_range(600)) - 300;
    end else if (pick < 75) begin
      c = last + int'($urandom_range(20000)) - 10000;
    end else if (pick < 88) begin
      c = int'($urandom_range(2 ** COUNT_W - 1)) + COUNT_MIN;
    end else if (pick < 94) begin
      c = COUNT_MAX;
    end else begin
      c = COUNT_MIN;
    end
    if (c > COUNT_MAX) c = COUNT_MAX;
    if (c < COUNT_MIN) c = COUNT_MIN;
    return c;
  endfunction

  // Gain for each random segment: full scale, random, one, random, a value up to 255, then the reset gain.
  function automatic logic [GAIN_W-1:0] segment_gain(input int seg);
    case (seg)
      0: return '1;
      2: return GAIN_W'(1);
      4: return GAIN_W'($urandom_range(1, 255));
      5: return GAIN_RESET;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Check every handshake at the rising edge: config, new request, result.
  always @(posedge clk) begin
    speed_t est;
    speed_t got;
    speed_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        est_gain = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        estimate_speed(in_tdata[COUNT_W-1:0], est);
        pending_speeds.push_back(row_typed ? row_speed : est);
      end
      if (out_tvalid && out_tready) begin
        got.raw = out_tdata[SPEED_W-1:0];
        got.filt = out_tdata[2*SPEED_W-1:SPEED_W];
        if (pending_speeds.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("Unexpected result: raw %0d filtered %0d", got.raw, got.filt);
          end
        end else begin
          want = pending_speeds.pop_front();
          if (got.raw !== want.raw || got.filt !== want.filt) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("Speed mismatch: raw expected %0d got %0d, filtered expected %0d got %0d",
                       want.raw, got.raw, want.filt, got.filt);
            end
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, plus the long hold-off when it is active.
  always @(negedge clk) begin
    out_tready <= !rx_hold && (int'($urandom_range(99)) >= recv_idle_pct);
  end

  // Long receiver hold-off so the block fills up and stalls its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Offer one counter sample; returns at the falling edge after it is taken.
  task automatic send_count(input int cnt);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'($unsigned(COUNT_W'(cnt)));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until every request has produced its result.
  task automatic drain_results();
    while (pending_speeds.size() != 0) @(negedge clk);
  endtask

  // Write the gain register while the block is idle.
  task automatic write_gain(input logic [GAIN_W-1:0] g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int prev_sample;
    dir_rows = '{
      // first request after reset: zero delta, zero speeds
      '{GAIN_KEEP, 0, 1'b1, 0, 0},
      // largest deltas both ways, then small and mid values while the ring fills
      '{GAIN_KEEP, 16383, 1'b0, 0, 0},
      '{GAIN_KEEP, -16384, 1'b0, 0, 0},
      '{GAIN_KEEP, 16383, 1'b0, 0, 0},
      '{GAIN_KEEP, -16384, 1'b0, 0, 0},
      '{GAIN_KEEP, 1, 1'b0, 0, 0},
      '{GAIN_KEEP, -1, 1'b0, 0, 0},
      '{GAIN_KEEP, 0, 1'b0, 0, 0},
      '{GAIN_KEEP, 8191, 1'b0, 0, 0},
      '{GAIN_KEEP, -8192, 1'b0, 0, 0},
      // ring wraps: oldest deltas start leaving the sum
      '{GAIN_KEEP, 10000, 1'b0, 0, 0},
      '{GAIN_KEEP, -10000, 1'b0, 0, 0},
      '{GAIN_KEEP, 5461, 1'b0, 0, 0},
      // zero gain: both speeds are zero whatever the delta
      '{0, 12345, 1'b1, 0, 0},
      '{GAIN_KEEP, -16384, 1'b1, 0, 0},
      // full-scale gain with the largest deltas
      '{65535, 16383, 1'b0, 0, 0},
      '{GAIN_KEEP, -16384, 1'b0, 0, 0},
      '{GAIN_KEEP, 16383, 1'b0, 0, 0},
      '{GAIN_KEEP, 16383, 1'b0, 0, 0},
      // smallest nonzero gain
      '{1, -16384, 1'b0, 0, 0},
      '{GAIN_KEEP, 16383, 1'b0, 0, 0},
      '{GAIN_KEEP, 0, 1'b0, 0, 0}
    };
    prev_sample = 0;

    // Reset once, then run with the sender idling lightly and the receiver heavily.
    send_idle_pct = 9;
    recv_idle_pct = 51;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows at the reset gain and at the gain extremes.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].gain != GAIN_KEEP) begin
        in_tvalid <= 1'b0;
        drain_results();
        write_gain(GAIN_W'(dir_rows[i].gain));
      end
      row_typed = dir_rows[i].typed;
      row_speed.raw = dir_rows[i].raw;
      row_speed.filt = dir_rows[i].filt;
      send_count(dir_rows[i].count);
      prev_sample = dir_rows[i].count;
    end
    in_tvalid <= 1'b0;
    row_typed = 1'b0;

    // Random segments, two per idle profile, each at its own gain.
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      drain_results();
      if (seg == 2) begin
        send_idle_pct = 51;
        recv_idle_pct = 9;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_gain(segment_gain(seg));
      if (seg == 4) begin
        pressure_go = 1'b1;
      end
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        prev_sample = next_encoder_count(prev_sample);
        send_count(prev_sample);
      end
      in_tvalid <= 1'b0;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_speeds.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
